// ===== sv/gbws_pkg.sv =====
// ----------------------------------------------------------------------------
// gbws_pkg: shared types and constants of the glyph box word segmenter
// Field widths, whitespace codes, register indexes and the divider
// request and response records.
// ----------------------------------------------------------------------------
package gbws_pkg;

  localparam int COORD_W   = 32;
  localparam int CODE_W    = 16;
  localparam int SIZE_W    = 24;
  localparam int SUM_W     = 44;
  localparam int LEN_W     = 20;
  localparam int FIRST_W   = 20;
  localparam int RATIO_W   = 16;
  localparam int QUOT_W    = 24;
  localparam int DIV_STEPS = QUOT_W;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [32:0] ONE_POINT = 33'd256;

  localparam logic [CODE_W-1:0] CODE_TAB   = 16'd9;
  localparam logic [CODE_W-1:0] CODE_LF    = 16'd10;
  localparam logic [CODE_W-1:0] CODE_CR    = 16'd13;
  localparam logic [CODE_W-1:0] CODE_SPACE = 16'd32;
  localparam logic [CODE_W-1:0] CODE_NBSP  = 16'd160;

  localparam logic REG_GAP_RATIO  = 1'b0;
  localparam logic REG_LINE_RATIO = 1'b1;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/gbws_div.sv =====
// ----------------------------------------------------------------------------
// gbws_div: radix-2 restoring divider for the mean font size
// Divides the size sum by the glyph count one quotient bit per cycle and
// saturates the quotient to its width when it would overflow.
// ----------------------------------------------------------------------------
module gbws_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gbws_pkg::div_req_t req,
  output gbws_pkg::div_rsp_t rsp
);
  import gbws_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LEN_W-1:0]  rem_r;
  logic [LEN_W-1:0]  dvs_r;
  logic [QUOT_W-1:0] sh_r;
  logic [LEN_W:0]    trial;
  logic [LEN_W+1:0]  diff;
  logic              overflow;

  assign trial    = {rem_r, sh_r[QUOT_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs_r};
  assign overflow = req.dividend >= {req.divisor, {QUOT_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= '0;
        if (overflow) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_r <= req.divisor;
      if (overflow) begin
        sh_r <= '1;
      end else begin
        rem_r <= req.dividend[SUM_W-1:QUOT_W];
        sh_r  <= req.dividend[QUOT_W-1:0];
      end
    end else if (busy_r) begin
      if (!diff[LEN_W+1]) begin
        rem_r <= diff[LEN_W-1:0];
        sh_r  <= {sh_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[LEN_W-1:0];
        sh_r  <= {sh_r[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = sh_r;

endmodule

// ===== sv/glyph_box_word_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_box_word_segmenter_unit: groups glyph boxes of a page into words
// A sequencer with one shared multiplier decides word breaks, and a shared
// divider produces the mean font size of each finished word.
// ----------------------------------------------------------------------------
// Usage:
// One glyph word enters on the in_ channel; in_tlast marks the last glyph of
// a page. Each finished word leaves on the out_ channel with its first index,
// glyph count, bounding box and mean font size; out_tlast marks the last
// word of a page. The cfg_ channel writes gap_ratio (index 0) and
// line_ratio (index 1) and is always ready.
// A glyph that ends no word takes the sequencer through the break tests in
// S_PREP, S_MULJ, S_MULG and S_DEC, the two S_MUL states on the shared 33x16
// multiplier, then S_UPD to update the page state and S_IDLE to take the
// next glyph. Each word it finishes adds S_DIVGO, S_DIVW and S_EMIT, with the
// radix-2 divider yielding one quotient bit per cycle unless the mean saturates.
// A glyph can finish up to two words.
// in_tready is high only while the sequencer is idle. The output register
// holds a word until it is taken; the next glyph is accepted meanwhile, but
// a new word waits in the sequencer until the register is free.
// A synchronous reset clears the page state, empties the output register and
// restores both ratios to their reset values.
// ----------------------------------------------------------------------------
module glyph_box_word_segmenter_unit #(
  parameter int INDEX_BITS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  // tdata: glyph_code[15:0], box_left[47:16], box_right[79:48],
  // box_bottom[111:80], box_top[143:112], glyph_size[167:144]
  input  logic [167:0] in_tdata,
  input  logic         in_tlast,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: first_glyph[19:0], glyph_total[39:20], word_left[71:40],
  // word_right[103:72], word_bottom[135:104], word_top[167:136],
  // mean_size[191:168]
  output logic [191:0] out_tdata,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  import gbws_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_MULJ  = 4'd2;
  localparam logic [3:0] S_MULG  = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_DIVGO = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;

  function automatic logic is_space(input logic [CODE_W-1:0] c);
    is_space = (c == CODE_SPACE) || (c == CODE_TAB) || (c == CODE_LF) ||
               (c == CODE_CR) || (c == CODE_NBSP);
  endfunction

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  logic [RATIO_W-1:0] gap_ratio_r;
  logic [RATIO_W-1:0] line_ratio_r;

  logic                      have_prev_r;
  logic                      in_word_r;
  logic [INDEX_BITS-1:0]     glyph_index_r;
  logic [INDEX_BITS-1:0]     start_index_r;
  logic signed [COORD_W-1:0] prev_left_r, prev_right_r, prev_bottom_r, prev_top_r;
  logic signed [COORD_W-1:0] acc_left_r, acc_right_r, acc_bottom_r, acc_top_r;
  logic [SUM_W-1:0]          size_sum_r;
  logic [LEN_W-1:0]          word_len_r;

  logic signed [COORD_W-1:0] left_r, right_r, bottom_r, top_r;
  logic [SIZE_W-1:0]         size_r;
  logic                      page_end_r;
  logic                      space_r;

  logic [33:0]        d_abs_r;
  logic [32:0]        h_r;
  logic [32:0]        w_r;
  logic signed [32:0] g_r;
  logic [48:0]        prod_r;
  logic               jump_r;
  logic               second_r;
  logic               final_r;
  logic [QUOT_W-1:0]  mean_r;

  logic         out_tvalid_r;
  logic         out_tlast_r;
  logic [191:0] out_tdata_r;

  logic signed [33:0] cen_cur, cen_prev, d_s;
  logic signed [32:0] h_s, w_s;
  logic [33:0]        d_abs;
  logic [32:0]        h_mag, h_val, w_val;
  logic [32:0]        mul_a;
  logic [RATIO_W-1:0] mul_b;
  logic [48:0]        mul_p;
  logic               jump_now;
  logic               gap_now;
  logic               brk;
  logic               out_free;
  logic               accept;
  logic [FIRST_W-1:0] first_w;

  div_req_t div_req;
  div_rsp_t div_rsp;

  gbws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  if (INDEX_BITS >= FIRST_W) begin : g_idx_wide
    assign first_w = start_index_r[FIRST_W-1:0];
  end else begin : g_idx_narrow
    assign first_w = {{(FIRST_W - INDEX_BITS){1'b0}}, start_index_r};
  end

  assign cen_cur  = 34'(top_r) + 34'(bottom_r);
  assign cen_prev = 34'(prev_top_r) + 34'(prev_bottom_r);
  assign d_s      = cen_cur - cen_prev;
  assign d_abs    = d_s[33] ? 34'(-d_s) : 34'(d_s);
  assign h_s      = 33'(top_r) - 33'(bottom_r);
  assign h_mag    = h_s[32] ? 33'(-h_s) : 33'(h_s);
  assign h_val    = (h_mag == '0) ? ONE_POINT : h_mag;
  assign w_s      = 33'(prev_right_r) - 33'(prev_left_r);
  assign w_val    = (w_s[32] || w_s == '0) ? ONE_POINT : 33'(w_s);

  assign mul_a = (state_r == S_MULJ) ? h_r : w_r;
  assign mul_b = (state_r == S_MULJ) ? line_ratio_r : gap_ratio_r;
  assign mul_p = {16'b0, mul_a} * {33'b0, mul_b};

  assign jump_now = {d_abs_r, 16'h0000} > {prod_r, 1'b0};
  assign gap_now  = !space_r && !g_r[32] && (g_r != '0) &&
                    ({1'b0, g_r[31:0], 16'h0000} > prod_r);
  assign brk      = (space_r || (have_prev_r && (jump_r || gap_now))) && in_word_r;

  assign out_free = !out_tvalid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  assign div_req.start    = (state_r == S_DIVGO);
  assign div_req.dividend = size_sum_r;
  assign div_req.divisor  = word_len_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_MULJ;
      S_MULJ:  state_nxt = S_MULG;
      S_MULG:  state_nxt = S_DEC;
      S_DEC:   state_nxt = brk ? S_DIVGO : S_UPD;
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW:  if (div_rsp.done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = second_r ? S_IDLE : S_UPD;
      end
      S_UPD: begin
        if (page_end_r && !space_r) state_nxt = S_DIVGO;
        else state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      gap_ratio_r   <= 16'd22938;
      line_ratio_r  <= 16'd32768;
      have_prev_r   <= 1'b0;
      in_word_r     <= 1'b0;
      glyph_index_r <= '0;
      second_r      <= 1'b0;
      final_r       <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_GAP_RATIO:  gap_ratio_r  <= cfg_data;
          REG_LINE_RATIO: line_ratio_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_EMIT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_DEC: begin
          if (brk) begin
            in_word_r <= 1'b0;
            second_r  <= 1'b0;
            final_r   <= page_end_r && space_r;
          end
        end
        S_EMIT: begin
          if (out_free && second_r) begin
            have_prev_r   <= 1'b0;
            in_word_r     <= 1'b0;
            glyph_index_r <= '0;
          end
        end
        S_UPD: begin
          if (page_end_r && !space_r) begin
            in_word_r     <= 1'b1;
            have_prev_r   <= 1'b1;
            glyph_index_r <= glyph_index_r + INDEX_BITS'(1);
            second_r      <= 1'b1;
            final_r       <= 1'b1;
          end else if (page_end_r) begin
            have_prev_r   <= 1'b0;
            in_word_r     <= 1'b0;
            glyph_index_r <= '0;
          end else begin
            have_prev_r   <= 1'b1;
            glyph_index_r <= glyph_index_r + INDEX_BITS'(1);
            if (!space_r) in_word_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          left_r     <= $signed(in_tdata[47:16]);
          right_r    <= $signed(in_tdata[79:48]);
          bottom_r   <= $signed(in_tdata[111:80]);
          top_r      <= $signed(in_tdata[143:112]);
          size_r     <= in_tdata[167:144];
          space_r    <= is_space(in_tdata[15:0]);
          page_end_r <= in_tlast;
        end
      end
      S_PREP: begin
        d_abs_r <= d_abs;
        h_r     <= h_val;
        w_r     <= w_val;
        g_r     <= 33'(left_r) - 33'(prev_right_r);
      end
      S_MULJ: prod_r <= mul_p;
      S_MULG: begin
        jump_r <= jump_now;
        prod_r <= mul_p;
      end
      S_DIVW: if (div_rsp.done) mean_r <= div_rsp.quotient;
      S_EMIT: begin
        if (out_free) begin
          out_tlast_r <= final_r;
          out_tdata_r <= {mean_r, acc_top_r, acc_bottom_r, acc_right_r, acc_left_r,
                          word_len_r, first_w};
        end
      end
      S_UPD: begin
        prev_left_r   <= left_r;
        prev_right_r  <= right_r;
        prev_bottom_r <= bottom_r;
        prev_top_r    <= top_r;
        if (!space_r) begin
          if (!in_word_r) begin
            start_index_r <= glyph_index_r;
            acc_left_r    <= left_r;
            acc_right_r   <= right_r;
            acc_bottom_r  <= bottom_r;
            acc_top_r     <= top_r;
            size_sum_r    <= {{(SUM_W - SIZE_W){1'b0}}, size_r};
            word_len_r    <= {{(LEN_W - 1){1'b0}}, 1'b1};
          end else begin
            if (left_r < acc_left_r) acc_left_r <= left_r;
            if (right_r > acc_right_r) acc_right_r <= right_r;
            if (bottom_r < acc_bottom_r) acc_bottom_r <= bottom_r;
            if (top_r > acc_top_r) acc_top_r <= top_r;
            if (word_len_r != LEN_MAX) begin
              word_len_r <= word_len_r + LEN_W'(1);
              size_sum_r <= size_sum_r + {{(SUM_W - SIZE_W){1'b0}}, size_r};
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = out_tdata_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input accepted again before the glyph was processed");

  a_word_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:20] != '0))
    else $error("word emitted with a zero glyph count");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIVW))
    else $error("divider finished outside the wait state");

  a_emit_loads_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> out_tvalid)
    else $error("emit state did not present a word");

endmodule

// ===== tb/tb_glyph_box_word_segmenter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_box_word_segmenter_unit: self-checking bench for the word segmenter
// Streams glyph words into the block and predicts every finished word: its
// first index, glyph count, bounding box, mean font size and page mark.
// A hand-built sequence hits the break thresholds, the whitespace codes,
// degenerate boxes, field extremes and page ends. Synthetic text lines follow,
// under several ratio settings and several patterns of idling and stalling.
// ----------------------------------------------------------------------------
module tb_glyph_box_word_segmenter_unit;
  import gbws_pkg::*;

  localparam int IDX_W = 20;
  localparam int WATCH_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int TEXT_PER_PHASE = 250;
  localparam longint SPAN = 64'sd536870912;
  localparam longint ORIGIN = 64'sd1048576;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] top;
    logic [SIZE_W-1:0]  size;
    logic               last;
  } glyph_t;

  typedef struct packed {
    logic [FIRST_W-1:0] first;
    logic [LEN_W-1:0]   total;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] top;
    logic [SIZE_W-1:0]  mean;
    logic               last;
  } word_t;

  function automatic longint sx(logic [COORD_W-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  class word_tracker;
    logic [RATIO_W-1:0] gap_q;
    logic [RATIO_W-1:0] line_q;
    glyph_t             prev;
    bit                 prev_ok;
    bit                 open;
    logic [IDX_W-1:0]   next_idx;
    word_t              cur;
    logic [SUM_W-1:0]   size_acc;
    word_t              pending_words[$];
    int                 fault_count;

    function new();
      gap_q = 16'd22938;
      line_q = 16'd32768;
      prev = '0;
      prev_ok = 1'b0;
      open = 1'b0;
      next_idx = '0;
      cur = '0;
      size_acc = '0;
      fault_count = 0;
    endfunction

    function void set_ratio(logic idx, logic [RATIO_W-1:0] val);
      if (idx == REG_GAP_RATIO) begin
        gap_q = val;
      end else begin
        line_q = val;
      end
    endfunction

    function void close_word();
      logic [SUM_W-1:0] q;
      q = size_acc / SUM_W'(cur.total);
      cur.mean = (q > SUM_W'(24'hFFFFFF)) ? '1 : q[SIZE_W-1:0];
      cur.last = 1'b0;
      pending_words.insert(pending_words.size(), cur);
      open = 1'b0;
    endfunction

    function void note_glyph(glyph_t g);
      bit blank;
      bit brk;
      int made;
      longint d;
      longint h;
      longint gp;
      longint w;
      blank = (g.code == CODE_SPACE) || (g.code == CODE_TAB) || (g.code == CODE_LF) ||
              (g.code == CODE_CR) || (g.code == CODE_NBSP);
      brk = blank;
      made = 0;
      if (prev_ok) begin
        d = (sx(g.top) + sx(g.bottom)) - (sx(prev.top) + sx(prev.bottom));
        h = sx(g.top) - sx(g.bottom);
        if (d < 0) d = -d;
        if (h < 0) h = -h;
        if (h == 0) h = 256;
        if (d * 65536 > 2 * h * longint'(line_q)) brk = 1'b1;
        if (!blank) begin
          gp = sx(g.left) - sx(prev.right);
          w = sx(prev.right) - sx(prev.left);
          if (w <= 0) w = 256;
          if (gp * 65536 > w * longint'(gap_q)) brk = 1'b1;
        end
      end
      if (brk && open) begin
        close_word();
        made++;
      end
      if (!blank) begin
        if (!open) begin
          open = 1'b1;
          cur.first = next_idx[FIRST_W-1:0];
          cur.left = g.left;
          cur.right = g.right;
          cur.bottom = g.bottom;
          cur.top = g.top;
          cur.total = 1;
          size_acc = SUM_W'(g.size);
        end else begin
          if (sx(g.left) < sx(cur.left)) cur.left = g.left;
          if (sx(g.right) > sx(cur.right)) cur.right = g.right;
          if (sx(g.bottom) < sx(cur.bottom)) cur.bottom = g.bottom;
          if (sx(g.top) > sx(cur.top)) cur.top = g.top;
          if (cur.total != LEN_MAX) begin
            cur.total++;
            size_acc = size_acc + SUM_W'(g.size);
          end
        end
      end
      prev = g;
      prev_ok = 1'b1;
      next_idx++;
      if (g.last) begin
        if (open) begin
          close_word();
          made++;
        end
        if (made > 0) pending_words[pending_words.size() - 1].last = 1'b1;
        prev_ok = 1'b0;
        open = 1'b0;
        next_idx = '0;
      end
    endfunction

    function void diff(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        fault_count++;
      end
    endfunction

    function void check_word(word_t got);
      word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: word with none expected, got %h", $time, got);
        fault_count++;
        return;
      end
      want = pending_words.pop_front();
      diff("first_glyph", 32'(want.first), 32'(got.first));
      diff("glyph_total", 32'(want.total), 32'(got.total));
      diff("word_left", want.left, got.left);
      diff("word_right", want.right, got.right);
      diff("word_bottom", want.bottom, got.bottom);
      diff("word_top", want.top, got.top);
      diff("mean_size", 32'(want.mean), 32'(got.mean));
      diff("page_final", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [167:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] out_tdata;
  logic         out_tlast;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = REG_GAP_RATIO;
  logic [15:0]  cfg_data = '0;

  word_tracker       tracker;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                quiet_cycles = 0;
  glyph_t            last_g = '0;
  longint            line_y = 0;
  logic [CODE_W-1:0] blank_codes [5] = '{CODE_SPACE, CODE_TAB, CODE_LF, CODE_CR, CODE_NBSP};
  int                idle_plan [6] = '{0, 48, 0, 36, 0, 36};
  int                stall_plan [6] = '{0, 0, 48, 36, 0, 36};

  glyph_box_word_segmenter_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    glyph_t g;
    word_t w;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        g.code = in_tdata[15:0];
        g.left = in_tdata[47:16];
        g.right = in_tdata[79:48];
        g.bottom = in_tdata[111:80];
        g.top = in_tdata[143:112];
        g.size = in_tdata[167:144];
        g.last = in_tlast;
        tracker.note_glyph(g);
      end
      if (out_tvalid && out_tready) begin
        w.first = out_tdata[19:0];
        w.total = out_tdata[39:20];
        w.left = out_tdata[71:40];
        w.right = out_tdata[103:72];
        w.bottom = out_tdata[135:104];
        w.top = out_tdata[167:136];
        w.mean = out_tdata[191:168];
        w.last = out_tlast;
        tracker.check_word(w);
      end
      if (cfg_valid && cfg_ready) tracker.set_ratio(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCH_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCH_LIMIT);
      $display("tb_glyph_box_word_segmenter_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic glyph_t mk(logic [CODE_W-1:0] c, longint l, longint r, longint b,
                                longint t, logic [SIZE_W-1:0] s, logic e);
    glyph_t g;
    g.code = c;
    g.left = 32'(l);
    g.right = 32'(r);
    g.bottom = 32'(b);
    g.top = 32'(t);
    g.size = s;
    g.last = e;
    return g;
  endfunction

  // Synthetic text: glyphs laid along lines, with gaps and centre shifts
  // steered around the current thresholds, plus some fully random glyphs.
  function automatic glyph_t next_glyph();
    glyph_t g;
    longint pen;
    longint ps;
    longint pw;
    longint gap;
    longint w;
    longint h;
    longint hh;
    longint d;
    longint lft;
    int unsigned roll;
    g = '0;
    if ($urandom_range(99) < 8) begin
      g.code = 16'($urandom);
      g.left = $urandom;
      g.right = $urandom;
      g.bottom = $urandom;
      g.top = $urandom;
      g.size = 24'($urandom);
      g.last = ($urandom_range(9) == 0);
      return g;
    end
    pen = sx(last_g.right);
    ps = sx(last_g.top) + sx(last_g.bottom);
    pw = sx(last_g.right) - sx(last_g.left);
    if (pw <= 0) pw = 256;
    if (pen > SPAN || pen < -SPAN || ps > SPAN || ps < -SPAN ||
        line_y > SPAN || line_y < -SPAN) begin
      pen = pick(-ORIGIN, ORIGIN);
      line_y = pick(-ORIGIN, ORIGIN);
      ps = 2 * line_y + 2560;
    end
    roll = $urandom_range(99);
    if (roll < 70) gap = pick(0, 40);
    else if (roll < 85) gap = ((pw * longint'(tracker.gap_q)) >>> 16) + pick(-1, 1);
    else if (roll < 93) gap = -pick(0, 512);
    else gap = pick(0, 5120);
    w = ($urandom_range(99) < 3) ? -pick(1, 512) : pick(0, 2048);
    h = ($urandom_range(99) < 5) ? 0 : pick(1536, 3584);
    roll = $urandom_range(99);
    if (roll < 6) begin
      line_y = line_y - pick(2560, 5120);
    end else if (roll < 14) begin
      hh = (h == 0) ? 256 : h;
      d = ((2 * hh * longint'(tracker.line_q)) >>> 16) + pick(-1, 1);
      if ($urandom_range(1) == 1) d = -d;
      line_y = (ps + d - h) >>> 1;
    end
    lft = pen + gap;
    g.left = 32'(lft);
    g.right = 32'(lft + w);
    g.bottom = 32'(line_y);
    g.top = 32'(line_y + h);
    if ($urandom_range(99) < 12) begin
      g.code = blank_codes[$urandom_range(4)];
    end else begin
      g.code = 16'(pick(33, 65535));
      if (g.code == CODE_NBSP) g.code = CODE_NBSP + 16'd1;
    end
    g.size = ($urandom_range(9) == 0) ? 24'($urandom) : 24'(pick(1536, 4096));
    g.last = ($urandom_range(39) == 0);
    return g;
  endfunction

  task automatic send_glyph(input glyph_t g);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {g.size, g.top, g.bottom, g.right, g.left, g.code};
    in_tlast <= g.last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    last_g = g;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Glyphs that finish no word give no sign of being done, so the pause
  // after the last word covers the sequencer and both divider passes.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        settle();
        case (p)
          1: begin
            write_reg(REG_GAP_RATIO, 16'h0000);
            write_reg(REG_LINE_RATIO, 16'h0000);
          end
          2: begin
            write_reg(REG_GAP_RATIO, 16'hFFFF);
            write_reg(REG_LINE_RATIO, 16'hFFFF);
          end
          5: begin
            write_reg(REG_GAP_RATIO, 16'd22938);
            write_reg(REG_LINE_RATIO, 16'd32768);
          end
          default: begin
            write_reg(REG_GAP_RATIO, 16'($urandom));
            write_reg(REG_LINE_RATIO, 16'($urandom));
          end
        endcase
      end
      idle_pct = idle_plan[p];
      stall_pct = stall_plan[p];
      if (p == 0) begin
        // Gaps just under and over the threshold, then centre shifts likewise.
        send_glyph(mk(16'd65, 0, 1280, 0, 2560, 24'd2560, 1'b0));
        send_glyph(mk(16'd66, 1280, 2560, 0, 2560, 24'd3072, 1'b0));
        send_glyph(mk(16'd67, 3008, 4288, 0, 2560, 24'd2048, 1'b0));
        send_glyph(mk(16'd68, 4737, 6017, 0, 2560, 24'd2300, 1'b0));
        send_glyph(mk(16'd69, 6017, 7297, 1280, 3840, 24'd2600, 1'b0));
        send_glyph(mk(16'd70, 7297, 8577, 2561, 5121, 24'd2700, 1'b0));
        // A flat glyph, then a zero-width and a negative-width previous glyph.
        send_glyph(mk(16'd71, 8577, 9857, 2561, 2561, 24'd2800, 1'b0));
        send_glyph(mk(16'd72, 9857, 9857, 2561, 2561, 24'd2900, 1'b0));
        send_glyph(mk(16'd73, 9947, 11227, 2561, 2561, 24'd3000, 1'b0));
        send_glyph(mk(16'd74, 11227, 11000, 2561, 2561, 24'd3100, 1'b0));
        send_glyph(mk(16'd75, 11089, 12369, 2561, 2561, 24'd3200, 1'b0));
        // Every whitespace code, then their neighbors.
        send_glyph(mk(CODE_SPACE, 12369, 12600, 2561, 2561, 24'd3300, 1'b0));
        send_glyph(mk(CODE_TAB, 12600, 12600, 2561, 2561, 24'd3300, 1'b0));
        send_glyph(mk(CODE_LF, 12600, 12600, 2561, 2561, 24'd3300, 1'b0));
        send_glyph(mk(CODE_CR, 12600, 12600, 2561, 2561, 24'd3300, 1'b0));
        send_glyph(mk(CODE_NBSP, 12600, 12600, 2561, 2561, 24'd3300, 1'b0));
        send_glyph(mk(16'd31, 12600, 13880, 0, 2560, 24'd1, 1'b0));
        send_glyph(mk(16'd161, 13880, 15160, 0, 2560, 24'd2, 1'b0));
        send_glyph(mk(16'd33, 15160, 16440, 0, 2560, 24'd3, 1'b0));
        send_glyph(mk(16'd0, 16440, 17720, 0, 2560, 24'd4, 1'b1));
        // Extreme boxes and sizes, closed by whitespace at page end.
        send_glyph(mk(16'hFFFF, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                      64'sd2147483647, 24'hFFFFFF, 1'b0));
        send_glyph(mk(16'd12, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                      -64'sd2147483648, 24'h000000, 1'b0));
        send_glyph(mk(CODE_SPACE, 0, 256, 0, 256, 24'd0, 1'b1));
        // Page end with nothing open, then two words from one glyph.
        send_glyph(mk(CODE_SPACE, 0, 256, 0, 256, 24'd0, 1'b1));
        send_glyph(mk(16'd97, 0, 1280, 0, 2560, 24'd2560, 1'b0));
        send_glyph(mk(16'd98, 5000, 6280, 0, 2560, 24'd2816, 1'b1));
      end
      repeat (TEXT_PER_PHASE) send_glyph(next_glyph());
    end
    settle();
    if (tracker.fault_count == 0) begin
      $display("tb_glyph_box_word_segmenter_unit: done, clean");
    end else begin
      $display("tb_glyph_box_word_segmenter_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== glyph_box_word_segmenter_unit.f =====
sv/gbws_pkg.sv
sv/gbws_div.sv
sv/glyph_box_word_segmenter_unit.sv
tb/tb_glyph_box_word_segmenter_unit.sv
